@@ rtl/bap_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the block-average pixelation unit.
package bap_pkg;

  localparam int ChanW      = 8;
  localparam int CoordW     = 11;
  localparam int CountW     = 13;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 12;
  localparam int BlockCfgW  = 7;

  localparam logic [CfgIdxW-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BLOCK_SIZE   = 2'd2;

  localparam int FrameWidthRst  = 640;
  localparam int FrameHeightRst = 480;
  localparam int BlockSizeRst   = 15;

  typedef logic [ChanW-1:0] chan_t;

  typedef struct packed {
    chan_t c0;
    chan_t c1;
    chan_t c2;
  } pix_t;

endpackage

@@ rtl/bap_accum.sv @@
`timescale 1ns / 1ps
// Band sum memory with read-modify-write and write forwarding.
module bap_accum #(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11,
  parameter int SUM_W  = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc_en,
  input  logic [ADDR_W-1:0]    acc_addr,
  input  logic                 acc_first,
  input  bap_pkg::pix_t        acc_pix,
  output logic [3*SUM_W-1:0]   sums
);

  logic [3*SUM_W-1:0] mem [DEPTH];
  logic [3*SUM_W-1:0] rdata_r;
  logic               b_valid_r;
  logic [ADDR_W-1:0]  b_addr_r;
  logic               b_first_r;
  bap_pkg::pix_t      b_pix_r;
  logic               fwd_valid_r;
  logic [ADDR_W-1:0]  fwd_addr_r;
  logic [3*SUM_W-1:0] fwd_data_r;
  logic [3*SUM_W-1:0] old_sums;

  // Read at acceptance, write back in the following cycle; reads see the old data.
  always_ff @(posedge clk) begin
    if (acc_en) begin
      rdata_r <= mem[acc_addr];
    end
    if (b_valid_r) begin
      mem[b_addr_r] <= sums;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      b_valid_r <= acc_en;
      if (b_valid_r) begin
        fwd_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_en) begin
      b_addr_r  <= acc_addr;
      b_first_r <= acc_first;
      b_pix_r   <= acc_pix;
    end
    if (b_valid_r) begin
      fwd_addr_r <= b_addr_r;
      fwd_data_r <= sums;
    end
  end

  // The first pixel of a block in a band starts from zero, so the memory
  // never needs clearing. The forward register always holds the latest write.
  always_comb begin
    priority if (b_first_r) begin
      old_sums = '0;
    end else if (fwd_valid_r && (fwd_addr_r == b_addr_r)) begin
      old_sums = fwd_data_r;
    end else begin
      old_sums = rdata_r;
    end
  end

  assign sums[0*SUM_W +: SUM_W] = old_sums[0*SUM_W +: SUM_W] + SUM_W'(b_pix_r.c0);
  assign sums[1*SUM_W +: SUM_W] = old_sums[1*SUM_W +: SUM_W] + SUM_W'(b_pix_r.c1);
  assign sums[2*SUM_W +: SUM_W] = old_sums[2*SUM_W +: SUM_W] + SUM_W'(b_pix_r.c2);

endmodule

@@ rtl/bap_div.sv @@
`timescale 1ns / 1ps
// Three-channel restoring divider with round-half-to-even.
module bap_div #(
  parameter int N_W   = 14,
  parameter int SUM_W = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [N_W-1:0]     n,
  input  logic [3*SUM_W-1:0] sums,
  input  logic               res_ack,
  output logic               busy,
  output logic               res_valid,
  output bap_pkg::pix_t      res
);

  localparam int QUOT_W = bap_pkg::ChanW;
  localparam int STEP_W = $clog2(QUOT_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r;
  logic [N_W-1:0]    n_r;
  logic [N_W-1:0]    rem_r [3];
  logic [QUOT_W-1:0] lo_r  [3];
  logic [QUOT_W-1:0] q_r   [3];
  logic [N_W:0]      trial [3];
  logic              take  [3];
  logic [N_W-1:0]    rem_step [3];
  logic [N_W:0]      twice [3];
  logic              round_up [3];
  logic [QUOT_W-1:0] avg   [3];

  // The mean is below 256, so the sum shifted down by eight is already below
  // the divisor and only eight quotient bits remain to be found.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      trial[k]    = {rem_r[k], lo_r[k][QUOT_W-1]};
      take[k]     = trial[k] >= {1'b0, n_r};
      rem_step[k] = take[k] ? N_W'(trial[k] - {1'b0, n_r}) : N_W'(trial[k]);
      twice[k]    = {rem_r[k], 1'b0};
      round_up[k] = (twice[k] > {1'b0, n_r}) ||
                    ((twice[k] == {1'b0, n_r}) && q_r[k][0]);
      avg[k]      = q_r[k] + QUOT_W'(round_up[k]);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (step_r == STEP_W'(QUOT_W - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_ack) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_RUN) begin
        step_r <= step_r + STEP_W'(1);
      end else begin
        step_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && start) begin
      n_r <= n;
      for (int k = 0; k < 3; k++) begin
        rem_r[k] <= N_W'(sums[k*SUM_W + QUOT_W +: SUM_W - QUOT_W]);
        lo_r[k]  <= sums[k*SUM_W +: QUOT_W];
        q_r[k]   <= '0;
      end
    end else if (state_r == ST_RUN) begin
      for (int k = 0; k < 3; k++) begin
        rem_r[k] <= rem_step[k];
        lo_r[k]  <= {lo_r[k][QUOT_W-2:0], 1'b0};
        q_r[k]   <= {q_r[k][QUOT_W-2:0], take[k]};
      end
    end
  end

  assign busy      = state_r != ST_IDLE;
  assign res_valid = state_r == ST_DONE;
  assign res.c0    = avg[0];
  assign res.c1    = avg[1];
  assign res.c2    = avg[2];

endmodule

@@ rtl/block_average_pixelate_unit.sv @@
`timescale 1ns / 1ps
// Top level of the block-average pixelation unit.
//
// Pixels enter in raster order on the in_ channel, one transfer per pixel;
// in_start_of_frame restarts the frame at that pixel. The frame is tiled
// into square blocks that are clipped at the right and bottom edges, and
// when the last pixel of a block is taken the block's indices, pixel count
// and rounded channel means leave on the out_ channel as one transfer.
// Configuration writes on cfg_ take effect at once and restart the frame;
// they must be made only while the unit is idle; the unit does not enforce this.
//
// A pixel that does not finish a block does not stop the input. A pixel that
// finishes a block holds in_ready low while its band sums pass through the
// read-modify-write and the shared bit-serial divider, plus hand-off, and
// until the output register takes the block's result.
// The band sums live in one synchronous memory of MAX_LINE entries; it is
// never cleared, since the first pixel of every block starts from zero, so
// no clearing pass follows reset. Reset restores the default frame of
// 640 by 480 with 15-pixel blocks. When the receiver stalls, the finished
// result waits in the output register and the divider holds the next one,
// with in_ready low until the output register frees up.
module block_average_pixelate_unit #(
  parameter int MAX_LINE  = 2048,
  parameter int MAX_BLOCK = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bap_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [bap_pkg::CfgDataW-1:0]   cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_start_of_frame,
  input  bap_pkg::chan_t                 in_chan0,
  input  bap_pkg::chan_t                 in_chan1,
  input  bap_pkg::chan_t                 in_chan2,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bap_pkg::CoordW-1:0]     out_block_row,
  output logic [bap_pkg::CoordW-1:0]     out_block_col,
  output logic [bap_pkg::CountW-1:0]     out_pixel_count,
  output bap_pkg::chan_t                 out_avg0,
  output bap_pkg::chan_t                 out_avg1,
  output bap_pkg::chan_t                 out_avg2,
  output logic                           out_last_of_frame
);

  localparam int LINE_W = $clog2(MAX_LINE);
  localparam int WID_W  = $clog2(MAX_LINE + 1);
  localparam int OFS_W  = $clog2(MAX_BLOCK);
  localparam int BS_W   = $clog2(MAX_BLOCK + 1);
  localparam int CNT_W  = 2 * BS_W;
  localparam int SUM_W  = bap_pkg::ChanW + 2 * OFS_W;

  // A zero register value acts as one, and a large one is clamped.
  function automatic logic [WID_W-1:0] clamp_line(input logic [bap_pkg::CfgDataW-1:0] v);
    logic [WID_W-1:0] r;
    if (v == '0) begin
      r = WID_W'(1);
    end else if (32'(v) > 32'(MAX_LINE)) begin
      r = WID_W'(MAX_LINE);
    end else begin
      r = WID_W'(v);
    end
    return r;
  endfunction

  function automatic logic [BS_W-1:0] clamp_block(input logic [bap_pkg::BlockCfgW-1:0] v);
    logic [BS_W-1:0] r;
    if (v == '0) begin
      r = BS_W'(1);
    end else if (32'(v) > 32'(MAX_BLOCK)) begin
      r = BS_W'(MAX_BLOCK);
    end else begin
      r = BS_W'(v);
    end
    return r;
  endfunction

  // Frame geometry, stored already clamped.
  logic [WID_W-1:0]  width_r, height_r;
  logic [BS_W-1:0]   bsize_r;
  logic              cfg_restart;

  // Position of the next pixel.
  logic [LINE_W-1:0] col_pos_r, row_pos_r, bcol_r, brow_r;
  logic [OFS_W-1:0]  cib_r, rib_r;
  logic [LINE_W-1:0] col_pos_nxt, row_pos_nxt, bcol_nxt, brow_nxt;
  logic [OFS_W-1:0]  cib_nxt, rib_nxt;

  // Position of the pixel being offered, after a possible frame restart.
  logic [LINE_W-1:0] cur_col, cur_row, cur_bcol, cur_brow;
  logic [OFS_W-1:0]  cur_cib, cur_rib;
  logic              last_col, last_row, cib_wrap, rib_wrap, emit, first;
  logic [CNT_W-1:0]  cnt;
  logic              acc;
  bap_pkg::pix_t     pix;

  // Read-modify-write stage, holding the block information of the pixel.
  logic              emit_b_r;
  logic [LINE_W-1:0] b_brow_r, b_bcol_r;
  logic [CNT_W-1:0]  b_cnt_r;
  logic              b_lof_r;
  logic [3*SUM_W-1:0] sums;

  // Block information travelling alongside the divider.
  logic [LINE_W-1:0] d_brow_r, d_bcol_r;
  logic [CNT_W-1:0]  d_cnt_r;
  logic              d_lof_r;
  logic              div_busy, div_res_valid, out_load;
  bap_pkg::pix_t     div_res;

  logic              out_valid_r;

  assign cfg_restart = cfg_we && ((cfg_index == bap_pkg::CFG_FRAME_WIDTH) ||
                                  (cfg_index == bap_pkg::CFG_FRAME_HEIGHT) ||
                                  (cfg_index == bap_pkg::CFG_BLOCK_SIZE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= clamp_line(bap_pkg::CfgDataW'(bap_pkg::FrameWidthRst));
      height_r <= clamp_line(bap_pkg::CfgDataW'(bap_pkg::FrameHeightRst));
      bsize_r  <= clamp_block(bap_pkg::BlockCfgW'(bap_pkg::BlockSizeRst));
    end else if (cfg_we) begin
      unique case (cfg_index)
        bap_pkg::CFG_FRAME_WIDTH:  width_r  <= clamp_line(cfg_wdata);
        bap_pkg::CFG_FRAME_HEIGHT: height_r <= clamp_line(cfg_wdata);
        bap_pkg::CFG_BLOCK_SIZE:   bsize_r  <= clamp_block(cfg_wdata[bap_pkg::BlockCfgW-1:0]);
        default: ;
      endcase
    end
  end

  // A pixel is taken whenever no block result is on its way into the
  // divider and the divider is free.
  assign in_ready = !div_busy && !emit_b_r;
  assign acc      = in_valid && in_ready;

  assign pix.c0 = in_chan0;
  assign pix.c1 = in_chan1;
  assign pix.c2 = in_chan2;

  always_comb begin
    cur_col  = in_start_of_frame ? '0 : col_pos_r;
    cur_row  = in_start_of_frame ? '0 : row_pos_r;
    cur_bcol = in_start_of_frame ? '0 : bcol_r;
    cur_brow = in_start_of_frame ? '0 : brow_r;
    cur_cib  = in_start_of_frame ? '0 : cib_r;
    cur_rib  = in_start_of_frame ? '0 : rib_r;

    last_col = (WID_W'(cur_col) + WID_W'(1)) >= width_r;
    last_row = (WID_W'(cur_row) + WID_W'(1)) >= height_r;
    cib_wrap = (BS_W'(cur_cib) + BS_W'(1)) >= bsize_r;
    rib_wrap = (BS_W'(cur_rib) + BS_W'(1)) >= bsize_r;
    emit     = (last_col || cib_wrap) && (last_row || rib_wrap);
    first    = (cur_cib == '0) && (cur_rib == '0);
    cnt      = CNT_W'(BS_W'(cur_cib) + BS_W'(1)) * CNT_W'(BS_W'(cur_rib) + BS_W'(1));
  end

  // Raster walk: across the row, then down, wrapping to a new frame after
  // the last pixel; a configuration write restarts the frame.
  always_comb begin
    col_pos_nxt = col_pos_r;
    row_pos_nxt = row_pos_r;
    bcol_nxt    = bcol_r;
    brow_nxt    = brow_r;
    cib_nxt     = cib_r;
    rib_nxt     = rib_r;
    if (cfg_restart) begin
      col_pos_nxt = '0;
      row_pos_nxt = '0;
      bcol_nxt    = '0;
      brow_nxt    = '0;
      cib_nxt     = '0;
      rib_nxt     = '0;
    end else if (acc) begin
      row_pos_nxt = cur_row;
      brow_nxt    = cur_brow;
      rib_nxt     = cur_rib;
      if (last_col) begin
        col_pos_nxt = '0;
        cib_nxt     = '0;
        bcol_nxt    = '0;
        if (last_row) begin
          row_pos_nxt = '0;
          rib_nxt     = '0;
          brow_nxt    = '0;
        end else begin
          row_pos_nxt = cur_row + LINE_W'(1);
          if (rib_wrap) begin
            rib_nxt  = '0;
            brow_nxt = cur_brow + LINE_W'(1);
          end else begin
            rib_nxt  = cur_rib + OFS_W'(1);
          end
        end
      end else begin
        col_pos_nxt = cur_col + LINE_W'(1);
        if (cib_wrap) begin
          cib_nxt  = '0;
          bcol_nxt = cur_bcol + LINE_W'(1);
        end else begin
          cib_nxt  = cur_cib + OFS_W'(1);
          bcol_nxt = cur_bcol;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
      bcol_r    <= '0;
      brow_r    <= '0;
      cib_r     <= '0;
      rib_r     <= '0;
      emit_b_r  <= 1'b0;
    end else begin
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
      bcol_r    <= bcol_nxt;
      brow_r    <= brow_nxt;
      cib_r     <= cib_nxt;
      rib_r     <= rib_nxt;
      emit_b_r  <= acc && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      b_brow_r <= cur_brow;
      b_bcol_r <= cur_bcol;
      b_cnt_r  <= cnt;
      b_lof_r  <= last_col && last_row;
    end
    if (emit_b_r) begin
      d_brow_r <= b_brow_r;
      d_bcol_r <= b_bcol_r;
      d_cnt_r  <= b_cnt_r;
      d_lof_r  <= b_lof_r;
    end
  end

  bap_accum #(
    .DEPTH  (MAX_LINE),
    .ADDR_W (LINE_W),
    .SUM_W  (SUM_W)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc_en    (acc),
    .acc_addr  (cur_bcol),
    .acc_first (first),
    .acc_pix   (pix),
    .sums      (sums)
  );

  // The updated sums of a finishing block go straight into the divider.
  bap_div #(
    .N_W   (CNT_W),
    .SUM_W (SUM_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (emit_b_r),
    .n         (b_cnt_r),
    .sums      (sums),
    .res_ack   (out_load),
    .busy      (div_busy),
    .res_valid (div_res_valid),
    .res       (div_res)
  );

  // Output register: loads when empty or when its transfer completes.
  assign out_load = div_res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_block_row     <= bap_pkg::CoordW'(d_brow_r);
      out_block_col     <= bap_pkg::CoordW'(d_bcol_r);
      out_pixel_count   <= bap_pkg::CountW'(d_cnt_r);
      out_avg0          <= div_res.c0;
      out_avg1          <= div_res.c1;
      out_avg2          <= div_res.c2;
      out_last_of_frame <= d_lof_r;
    end
  end

  assign out_valid = out_valid_r;

  // The divider is never started while it still works on a block.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit_b_r |-> !div_busy)
    else $error("divider started while busy");

  // A block in the divider always has at least one pixel.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (d_cnt_r != '0))
    else $error("divider holds an empty block");

  // The raster position stays inside the configured frame.
  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (WID_W'(col_pos_r) < width_r) && (WID_W'(row_pos_r) < height_r))
    else $error("position outside the frame");

  // A new result appears only when the divider had one ready.
  a_out_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(div_res_valid))
    else $error("result appeared without divider output");

endmodule

@@ sim/tb_block_average_pixelate_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the block-average pixelation unit, with its block scoreboard.

localparam int LineMax  = 2048;
localparam int BlockMax = 64;

typedef struct packed {
  logic [bap_pkg::CoordW-1:0] blk_row;
  logic [bap_pkg::CoordW-1:0] blk_col;
  logic [bap_pkg::CountW-1:0] pix_count;
  bap_pkg::chan_t             avg0;
  bap_pkg::chan_t             avg1;
  bap_pkg::chan_t             avg2;
  logic                       frame_end;
} block_result_t;

class bap_scoreboard;
  bit [11:0]       frame_width;
  bit [11:0]       frame_height;
  bit [6:0]        block_size;
  bit [19:0]       band_sum [LineMax][3];
  int unsigned     row_pos, col_pos, row_in_blk, col_in_blk, blk_col;
  block_result_t   expected_blocks [$];
  int              failures;
  int              blocks_checked;
  int              frames_closed;

  function new();
    frame_width    = bap_pkg::FrameWidthRst;
    frame_height   = bap_pkg::FrameHeightRst;
    block_size     = bap_pkg::BlockSizeRst;
    failures       = 0;
    blocks_checked = 0;
    frames_closed  = 0;
    restart();
  endfunction

  function void restart();
    foreach (band_sum[i, k]) band_sum[i][k] = '0;
    row_pos    = 0;
    col_pos    = 0;
    row_in_blk = 0;
    col_in_blk = 0;
    blk_col    = 0;
  endfunction

  function int unsigned clamp_reg(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function int pending();
    return expected_blocks.size();
  endfunction

  // A write to any of the three geometry registers restarts the frame.
  function void write_reg(logic [bap_pkg::CfgIdxW-1:0] idx,
                          logic [bap_pkg::CfgDataW-1:0] val);
    case (idx)
      bap_pkg::CFG_FRAME_WIDTH:  frame_width = val;
      bap_pkg::CFG_FRAME_HEIGHT: frame_height = val;
      bap_pkg::CFG_BLOCK_SIZE:   block_size = val[bap_pkg::BlockCfgW-1:0];
      default:                   return;
    endcase
    restart();
  endfunction

  function void note_pixel(bit sof, bap_pkg::chan_t c0, bap_pkg::chan_t c1,
                           bap_pkg::chan_t c2);
    int unsigned    w, h, bs, bc, n, q, r;
    bit             last_col, last_row, end_col, end_row;
    bap_pkg::chan_t pix [3];
    bap_pkg::chan_t means [3];
    block_result_t  blk;
    w  = clamp_reg(frame_width, LineMax);
    h  = clamp_reg(frame_height, LineMax);
    bs = clamp_reg(block_size, BlockMax);
    if (sof) restart();
    bc  = blk_col % LineMax;
    pix = '{c0, c1, c2};
    for (int k = 0; k < 3; k++) band_sum[bc][k] += pix[k];
    last_col = (col_pos + 1 >= w);
    last_row = (row_pos + 1 >= h);
    end_col  = last_col || (col_in_blk + 1 >= bs);
    end_row  = last_row || (row_in_blk + 1 >= bs);
    if (end_col && end_row) begin
      n = (col_in_blk + 1) * (row_in_blk + 1);
      // Round to nearest, ties go to the even quotient.
      for (int k = 0; k < 3; k++) begin
        q = band_sum[bc][k] / n;
        r = band_sum[bc][k] % n;
        if (2 * r > n || (2 * r == n && (q % 2) == 1)) q++;
        means[k] = bap_pkg::chan_t'(q);
        band_sum[bc][k] = '0;
      end
      blk.blk_row   = bap_pkg::CoordW'(row_pos / bs);
      blk.blk_col   = bap_pkg::CoordW'(bc);
      blk.pix_count = bap_pkg::CountW'(n);
      blk.avg0      = means[0];
      blk.avg1      = means[1];
      blk.avg2      = means[2];
      blk.frame_end = last_col && last_row;
      expected_blocks.push_back(blk);
    end
    if (last_col) begin
      col_pos    = 0;
      col_in_blk = 0;
      blk_col    = 0;
      if (last_row) begin
        restart();
      end else begin
        row_pos++;
        row_in_blk = (row_in_blk + 1 >= bs) ? 0 : row_in_blk + 1;
      end
    end else begin
      col_pos++;
      if (col_in_blk + 1 >= bs) begin
        col_in_blk = 0;
        blk_col++;
      end else begin
        col_in_blk++;
      end
    end
  endfunction

  function void check_block(block_result_t got);
    block_result_t want;
    if (expected_blocks.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("Unexpected block row %0d col %0d count %0d",
                 got.blk_row, got.blk_col, got.pix_count);
      return;
    end
    want = expected_blocks.pop_front();
    blocks_checked++;
    if (want.frame_end) frames_closed++;
    if (got.blk_row !== want.blk_row || got.blk_col !== want.blk_col ||
        got.pix_count !== want.pix_count || got.avg0 !== want.avg0 ||
        got.avg1 !== want.avg1 || got.avg2 !== want.avg2 ||
        got.frame_end !== want.frame_end) begin
      failures++;
      if (failures <= 10)
        $display("Block mismatch: expected row %0d col %0d count %0d avg %0d/%0d/%0d end %0b, %s",
                 want.blk_row, want.blk_col, want.pix_count, want.avg0, want.avg1,
                 want.avg2, want.frame_end, "see next line");
      if (failures <= 10)
        $display("                got      row %0d col %0d count %0d avg %0d/%0d/%0d end %0b",
                 got.blk_row, got.blk_col, got.pix_count, got.avg0, got.avg1,
                 got.avg2, got.frame_end);
    end
  endfunction
endclass

module tb_block_average_pixelate_unit;

  // Settle time after the last expected block, while the unit finishes any
  // pixel still in flight.
  localparam int SettleCycles = 24;
  localparam int DrainLimit   = 5000;
  localparam int HoldCycles   = 300;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         cfg_we;
  logic [bap_pkg::CfgIdxW-1:0]  cfg_index;
  logic [bap_pkg::CfgDataW-1:0] cfg_wdata;
  logic                         in_valid;
  logic                         in_ready;
  logic                         in_start_of_frame;
  bap_pkg::chan_t               in_chan0, in_chan1, in_chan2;
  logic                         out_valid;
  logic                         out_ready;
  logic [bap_pkg::CoordW-1:0]   out_block_row, out_block_col;
  logic [bap_pkg::CountW-1:0]   out_pixel_count;
  bap_pkg::chan_t               out_avg0, out_avg1, out_avg2;
  logic                         out_last_of_frame;

  bap_scoreboard sb;

  // When steady is set, neither side idles. Each increment of hold_requests
  // asks the receiver for one long hold-off.
  bit steady = 1'b0;
  int hold_requests = 0;
  int pixels_sent = 0;
  int settings_used = 1;

  block_average_pixelate_unit #(
    .MAX_LINE  (LineMax),
    .MAX_BLOCK (BlockMax)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_start_of_frame (in_start_of_frame),
    .in_chan0          (in_chan0),
    .in_chan1          (in_chan1),
    .in_chan2          (in_chan2),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_block_row     (out_block_row),
    .out_block_col     (out_block_col),
    .out_pixel_count   (out_pixel_count),
    .out_avg0          (out_avg0),
    .out_avg1          (out_avg1),
    .out_avg2          (out_avg2),
    .out_last_of_frame (out_last_of_frame)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offers one pixel and returns at the falling edge after its transfer.
  // The task is entered at a falling edge; idle cycles are inserted before
  // the offer, so valid is never dropped and raised in the same time step.
  task automatic send_pixel(bit sof, bap_pkg::chan_t c0, bap_pkg::chan_t c1,
                            bap_pkg::chan_t c2);
    while (!steady && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_start_of_frame <= sof;
    in_chan0          <= c0;
    in_chan1          <= c1;
    in_chan2          <= c2;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_pixel(sof, c0, c1, c2);
    pixels_sent++;
    @(negedge clk);
  endtask

  // Mostly uniform channel values, with the two extremes now and then so
  // that both ends of the channel range come up often.
  function automatic bap_pkg::chan_t random_chan();
    if ($urandom_range(9) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return bap_pkg::chan_t'($urandom_range(255));
  endfunction

  // Lets every expected block arrive, then lets the unit settle, since a
  // pixel that finishes no block may still be in flight.
  task automatic wait_for_blocks();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (sb.pending() != 0 && waited < DrainLimit) begin
      @(negedge clk);
      waited++;
    end
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic drive_reg(logic [bap_pkg::CfgIdxW-1:0] idx,
                           logic [bap_pkg::CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  // Registers are only written once the unit has gone idle.
  task automatic set_geometry(logic [bap_pkg::CfgDataW-1:0] w,
                              logic [bap_pkg::CfgDataW-1:0] h,
                              logic [bap_pkg::CfgDataW-1:0] bs);
    wait_for_blocks();
    drive_reg(bap_pkg::CFG_FRAME_WIDTH, w);
    drive_reg(bap_pkg::CFG_FRAME_HEIGHT, h);
    drive_reg(bap_pkg::CFG_BLOCK_SIZE, bs);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // One phase: a new geometry and a run of random pixels. The first pixel
  // usually carries start of frame, and a few later ones restart the frame
  // mid-way. Phases mostly end mid-frame, so the next write restarts it.
  task automatic run_phase(logic [bap_pkg::CfgDataW-1:0] w,
                           logic [bap_pkg::CfgDataW-1:0] h,
                           logic [bap_pkg::CfgDataW-1:0] bs, int npix, bit hold_out);
    bit sof;
    set_geometry(w, h, bs);
    if (hold_out) hold_requests++;
    for (int i = 0; i < npix; i++) begin
      sof = (i == 0) ? ($urandom_range(3) != 0) : ($urandom_range(99) < 2);
      send_pixel(sof, random_chan(), random_chan(), random_chan());
    end
  endtask

  // Receiver: ready is driven at the falling edge. A hold-off request keeps
  // ready low, counting down from HoldCycles, while the sender keeps offering,
  // so the output register and the divider fill and in_ready drops.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 26);
      end
    end
  end

  // Every block transfer is checked against the oldest expected block.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_block(block_result_t'{out_block_row, out_block_col, out_pixel_count,
                                     out_avg0, out_avg1, out_avg2, out_last_of_frame});
  end

  initial begin
    sb                = new();
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = bap_pkg::CFG_FRAME_WIDTH;
    cfg_wdata         = '0;
    in_valid          = 1'b0;
    in_start_of_frame = 1'b0;
    in_chan0          = '0;
    in_chan1          = '0;
    in_chan2          = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, without idling. At the reset geometry of 640 by 480
    // these three pixels finish no block.
    steady = 1'b1;
    send_pixel(1'b1, 8'h00, 8'h00, 8'h00);
    send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(1'b0, 8'hAA, 8'h55, 8'h0F);

    // A 3 by 2 frame of 2-pixel blocks: one full 2 by 2 block and one block
    // clipped to a single column. The clipped block's channel sums are
    // 509, 1 and 3 over two pixels, so all three means are exact ties.
    set_geometry(12'd3, 12'd2, 12'd2);
    send_pixel(1'b1, 8'h00, 8'h01, 8'hFF);
    send_pixel(1'b0, 8'h01, 8'h02, 8'hFE);
    send_pixel(1'b0, 8'hFF, 8'h00, 8'h01);
    send_pixel(1'b0, 8'h80, 8'h7F, 8'h01);
    send_pixel(1'b0, 8'h80, 8'h80, 8'hFE);
    send_pixel(1'b0, 8'hFE, 8'h01, 8'h02);
    // Frame overrun: a whole second frame without start of frame.
    for (int i = 0; i < 6; i++)
      send_pixel(1'b0, bap_pkg::chan_t'(i * 51), bap_pkg::chan_t'(255 - i * 51),
                 bap_pkg::chan_t'(i * 17));
    // Two pixels into the next frame, then start of frame cuts it short.
    send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
    for (int i = 0; i < 6; i++)
      send_pixel(i == 0, (i % 2) ? 8'hFF : 8'h00, 8'h55, (i % 2) ? 8'h00 : 8'hFF);
    steady = 1'b0;

    // Random part. Zero registers count as one; oversized ones are clamped;
    // the block size keeps only its low seven bits.
    run_phase(12'd0, 12'd0, 12'd0, 40, 1'b0);
    run_phase(12'd5, 12'd4, 12'd2, 60, 1'b0);
    steady = 1'b1;
    run_phase(12'd7, 12'd5, 12'd3, 100, 1'b0);
    steady = 1'b0;
    run_phase(12'hFFF, 12'd1, 12'd1, 150, 1'b0);
    run_phase(12'd3, 12'd70, 12'd64, 220, 1'b0);
    run_phase(12'd8, 12'd8, 12'd127, 128, 1'b0);
    run_phase(12'd16, 12'd16, 12'd4, 300, 1'b0);
    run_phase(12'd10, 12'd6, 12'hF83, 120, 1'b0);
    run_phase(12'd1, 12'h800, 12'd5, 200, 1'b0);
    run_phase(12'd13, 12'd9, 12'd4, 300, 1'b1);
    repeat (3)
      run_phase(bap_pkg::CfgDataW'($urandom_range(1, 20)),
                bap_pkg::CfgDataW'($urandom_range(1, 20)),
                bap_pkg::CfgDataW'($urandom_range(1, 8)), 110, 1'b0);

    wait_for_blocks();
    if (sb.pending() != 0) begin
      sb.failures++;
      $display("%0d expected blocks never left the unit", sb.pending());
    end
    $display("Summary: %0d pixels over %0d geometries, %0d blocks checked, %0d frames closed.",
             pixels_sent, settings_used, sb.blocks_checked, sb.frames_closed);
    $display("Covered zero, clamped and masked registers, restarts, overrun and a long stall.");
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5ms;
    $display("Timeout: the unit stopped making progress");
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ files.f @@
rtl/bap_pkg.sv
rtl/bap_accum.sv
rtl/bap_div.sv
rtl/block_average_pixelate_unit.sv
sim/tb_block_average_pixelate_unit.sv
